/* rtl/scsba_pkg.sv */
// shared types, codes and constants of the size-class slab allocator
`default_nettype none
package scsba_pkg;

    localparam int SLOTS_PER_CLASS_DEF = 1024;
    localparam int NUM_CLASSES         = 3;
    localparam int CFG_ADDR_W          = 4;
    localparam int SLOT_INDEX_W        = 10;

    localparam logic [31:0] MAX_REQ_RESET = 32'd4194304;
    localparam logic [31:0] BASE_RESET    = 32'd0;

    typedef enum logic [1:0] {
        ST_GRANT    = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_REJECT   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CLS_8  = 2'd0,
        CLS_16 = 2'd1,
        CLS_32 = 2'd2
    } t_class;

    typedef enum logic [1:0] {
        REG_MAX_REQ = 2'd0,
        REG_BASE8   = 2'd1,
        REG_BASE16  = 2'd2,
        REG_BASE32  = 2'd3
    } t_reg_idx;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic [31:0] max_req;
        logic [31:0] base8;
        logic [31:0] base16;
        logic [31:0] base32;
    } t_cfg;

    typedef struct packed {
        logic    load;
        logic    next_cls;
        logic    emit;
        t_status kind;
    } t_dp_cmd;

    typedef struct packed {
        logic too_large;
        logic fits;
        logic has_free;
        logic last_cls;
        logic out_free;
    } t_dp_sts;

    // log2 of the slot size of a class
    function automatic logic [2:0] class_shift(input t_class cls);
        logic [2:0] sh;
        case (cls)
            CLS_8:   sh = 3'd3;
            CLS_16:  sh = 3'd4;
            CLS_32:  sh = 3'd5;
            default: sh = 3'd5;
        endcase
        return sh;
    endfunction

    function automatic t_class next_class(input t_class cls);
        t_class nx;
        case (cls)
            CLS_8:   nx = CLS_16;
            CLS_16:  nx = CLS_32;
            default: nx = CLS_32;
        endcase
        return nx;
    endfunction

endpackage
`default_nettype wire

/* rtl/scsba_cfg.sv */
// configuration register file behind the apb-style port
`default_nettype none
module scsba_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scsba_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    output scsba_pkg::t_cfg                       o_cfg
);
    import scsba_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_req <= MAX_REQ_RESET;
            r_cfg.base8   <= BASE_RESET;
            r_cfg.base16  <= BASE_RESET;
            r_cfg.base32  <= BASE_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_REQ: r_cfg.max_req <= pwdata;
                REG_BASE8:   r_cfg.base8   <= pwdata;
                REG_BASE16:  r_cfg.base16  <= pwdata;
                REG_BASE32:  r_cfg.base32  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_REQ: prdata = r_cfg.max_req;
            REG_BASE8:   prdata = r_cfg.base8;
            REG_BASE16:  prdata = r_cfg.base16;
            REG_BASE32:  prdata = r_cfg.base32;
            default:     prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/scsba_ctrl.sv */
// controller: sequences one request through the slab classes
`default_nettype none
module scsba_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire scsba_pkg::t_dp_sts i_sts,
    output scsba_pkg::t_dp_cmd      o_cmd
);
    import scsba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_stall     = 1'b1;
        o_cmd.load     = 1'b0;
        o_cmd.next_cls = 1'b0;
        o_cmd.emit     = 1'b0;
        o_cmd.kind     = ST_FALLBACK;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.too_large) begin
                    o_cmd.kind = ST_REJECT;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_sts.fits && i_sts.has_free) begin
                    o_cmd.kind = ST_GRANT;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_sts.last_cls) begin
                    o_cmd.kind = ST_FALLBACK;
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.next_cls = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/scsba_dp.sv */
// datapath: request register, per-class fill counts, address and result registers
`default_nettype none
module scsba_dp #(
    parameter int SLOTS_PER_CLASS = scsba_pkg::SLOTS_PER_CLASS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire scsba_pkg::t_cfg                    i_cfg,
    input  wire logic [31:0]                        i_request_bytes,
    input  wire scsba_pkg::t_dp_cmd                 i_cmd,
    output scsba_pkg::t_dp_sts                      o_sts,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output logic [1:0]                              o_status,
    output logic [1:0]                              o_size_class,
    output logic [scsba_pkg::SLOT_INDEX_W-1:0]      o_slot_index,
    output logic [31:0]                             o_slot_address
);
    import scsba_pkg::*;

    localparam int CW = $clog2(SLOTS_PER_CLASS + 1);

    // first-free over a never-freed bitmap always hands out slots in index
    // order, so the used slots of a class are exactly 0 .. count-1
    logic [CW-1:0] r_cnt [NUM_CLASSES];
    logic [31:0]   r_req;
    t_class        r_cls;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [1:0]    r_size_class;
    logic [SLOT_INDEX_W-1:0] r_slot_index;
    logic [31:0]   r_slot_address;

    logic [CW-1:0] w_cnt_sel;
    logic [31:0]   w_base_sel;
    logic [31:0]   w_idx32;
    logic [31:0]   w_slot_bytes;
    logic [31:0]   w_addr;
    logic          w_grant;

    always_comb begin
        case (r_cls)
            CLS_8: begin
                w_cnt_sel  = r_cnt[0];
                w_base_sel = i_cfg.base8;
            end
            CLS_16: begin
                w_cnt_sel  = r_cnt[1];
                w_base_sel = i_cfg.base16;
            end
            default: begin
                w_cnt_sel  = r_cnt[2];
                w_base_sel = i_cfg.base32;
            end
        endcase
    end

    assign w_idx32      = {{(32-CW){1'b0}}, w_cnt_sel};
    assign w_slot_bytes = 32'd1 << class_shift(r_cls);
    assign w_addr       = w_base_sel + (w_idx32 << class_shift(r_cls));
    assign w_grant      = i_cmd.emit && (i_cmd.kind == ST_GRANT);

    assign o_sts.too_large = r_req > i_cfg.max_req;
    assign o_sts.fits      = r_req <= w_slot_bytes;
    assign o_sts.has_free  = w_cnt_sel != CW'(SLOTS_PER_CLASS);
    assign o_sts.last_cls  = r_cls == CLS_32;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_request_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls <= CLS_8;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_cls <= CLS_8;
            end else if (i_cmd.next_cls) begin
                r_cls <= next_class(r_cls);
            end
            if (w_grant) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                    if (r_cls == t_class'(2'(k))) begin
                        r_cnt[k] <= r_cnt[k] + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.kind;
            if (w_grant) begin
                r_size_class   <= r_cls;
                r_slot_index   <= w_idx32[SLOT_INDEX_W-1:0];
                r_slot_address <= w_addr;
            end else begin
                r_size_class   <= 2'd0;
                r_slot_index   <= '0;
                r_slot_address <= 32'd0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_size_class   = r_size_class;
    assign o_slot_index   = r_slot_index;
    assign o_slot_address = r_slot_address;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.out_free)
        else $error("result written while the output register still holds one");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grant |-> (o_sts.fits && o_sts.has_free && !o_sts.too_large))
        else $error("slot granted from a class that does not fit or is full");

    a_cnt8_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_grant && r_cls == CLS_8) |=> r_cnt[0] == $past(r_cnt[0]) + CW'(1))
        else $error("8-byte fill count did not advance on a grant");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(SLOTS_PER_CLASS)) && (r_cnt[1] <= CW'(SLOTS_PER_CLASS))
        && (r_cnt[2] <= CW'(SLOTS_PER_CLASS)))
        else $error("fill count ran past the class size");

endmodule
`default_nettype wire

/* rtl/size_class_slab_bitmap_allocator.sv */
// top level of the size-class slab allocator
//
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_stall      i_request_bytes
//  result    out        o_out_valid / i_out_stall    o_status o_size_class o_slot_index
//                                                    o_slot_address
//  config    in         psel penable pwrite pready   paddr pwdata prdata
//
// an item is taken when idle, then the class sequencer checks one slab class per
// cycle until a class grants or the search ends, then the result is registered and the
// next item can be taken the cycle after; the input is stalled while a class is checked
// each class keeps a fill count that reset clears at once; there is no clearing pass
// a result waiting on i_out_stall does not block acceptance of the next item; that
// item's result is held back until the output register frees
`default_nettype none
module size_class_slab_bitmap_allocator #(
    parameter int SLOTS_PER_CLASS = scsba_pkg::SLOTS_PER_CLASS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [31:0]                      i_request_bytes,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [1:0]                            o_status,
    output logic [1:0]                            o_size_class,
    output logic [scsba_pkg::SLOT_INDEX_W-1:0]    o_slot_index,
    output logic [31:0]                           o_slot_address,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scsba_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import scsba_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    scsba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scsba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    scsba_dp #(
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_request_bytes (i_request_bytes),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_size_class    (o_size_class),
        .o_slot_index    (o_slot_index),
        .o_slot_address  (o_slot_address)
    );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// self-checking bench for the size-class slab allocator: directed table, then random phases
`timescale 1ns / 100ps

module testbench;
    import scsba_pkg::*;

    localparam int SLOTS      = SLOTS_PER_CLASS_DEF;
    localparam int DIR_ROWS   = 20;
    localparam int NUM_PHASES = 6;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 10;

    typedef struct packed {
        t_status                 status;
        t_class                  size_class;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [31:0]             slot_address;
    } t_alloc_result;

    typedef struct {
        logic [31:0]   req;
        bit            typed;
        t_alloc_result want;
    } t_dir_row;

    localparam t_alloc_result UNTYPED = '{ST_FALLBACK, CLS_8, 10'd0, 32'd0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [31:0]           i_request_bytes;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [1:0]            o_size_class;
    logic [SLOT_INDEX_W-1:0] o_slot_index;
    logic [31:0]           o_slot_address;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    size_class_slab_bitmap_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_request_bytes (i_request_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_size_class    (o_size_class),
        .o_slot_index    (o_slot_index),
        .o_slot_address  (o_slot_address),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_cfg          cfg_shadow;
    int            slots_taken [NUM_CLASSES];
    t_alloc_result expected_results [$];
    t_alloc_result oldest;
    t_dir_row      dir_rows [DIR_ROWS];
    int            mismatches = 0;
    int            cycles = 0;
    int            stall_left = 0;
    logic          quiet_in = 1'b0;
    logic          quiet_out = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // slots are never freed and always taken lowest first, so each class map
    // is a filled prefix and its fill count says everything
    function automatic t_alloc_result predict_alloc(input logic [31:0] req);
        t_alloc_result r;
        logic [31:0]   slot_bytes;
        logic [31:0]   base;
        logic [31:0]   idx;
        int            c;
        r = UNTYPED;
        if (req > cfg_shadow.max_req) begin
            r.status = ST_REJECT;
            return r;
        end
        for (c = 0; c < NUM_CLASSES; c++) begin
            slot_bytes = 32'd8 << c;
            if (req <= slot_bytes && slots_taken[c] < SLOTS) begin
                case (t_class'(c))
                    CLS_8:   base = cfg_shadow.base8;
                    CLS_16:  base = cfg_shadow.base16;
                    default: base = cfg_shadow.base32;
                endcase
                idx            = slots_taken[c];
                r.status       = ST_GRANT;
                r.size_class   = t_class'(c);
                r.slot_index   = idx[SLOT_INDEX_W-1:0];
                r.slot_address = base + idx * slot_bytes;
                slots_taken[c]++;
                return r;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 8);
        if (r < 80) return $urandom_range(9, 16);
        if (r < 92) return $urandom_range(17, 32);
        if (r < 95) return $urandom_range(33, 4096);
        if (r < 98) return $urandom();
        // right at the limit and one past it
        return $urandom_range(0, 1) ? cfg_shadow.max_req : cfg_shadow.max_req + 32'd1;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [31:0] req, input bit typed,
                                input t_alloc_result typed_want);
        int            gap;
        bit            taken;
        t_alloc_result guess;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_request_bytes <= req;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                taken = 1'b1;
                guess = predict_alloc(req);
                expected_results.push_back(typed ? typed_want : guess);
            end
        end
        @(negedge i_clk);
    endtask

    // leaves psel high; the caller drops it after the last write
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MAX_REQ: cfg_shadow.max_req = value;
            REG_BASE8:   cfg_shadow.base8   = value;
            REG_BASE16:  cfg_shadow.base16  = value;
            default:     cfg_shadow.base32  = value;
        endcase
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || quiet_out) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 99) < 50) begin
            i_out_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing pending, status %0d class %0d index %0d addr %h",
                         $time, o_status, o_size_class, o_slot_index, o_slot_address);
                mismatches++;
            end else begin
                oldest = expected_results.pop_front();
                if (o_status !== oldest.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, oldest.status, o_status);
                    mismatches++;
                end
                if (o_size_class !== oldest.size_class) begin
                    $display("%0t: size_class expected %0d, got %0d",
                             $time, oldest.size_class, o_size_class);
                    mismatches++;
                end
                if (o_slot_index !== oldest.slot_index) begin
                    $display("%0t: slot_index expected %0d, got %0d",
                             $time, oldest.slot_index, o_slot_index);
                    mismatches++;
                end
                if (o_slot_address !== oldest.slot_address) begin
                    $display("%0t: slot_address expected %h, got %h",
                             $time, oldest.slot_address, o_slot_address);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results pending", $time, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          k;
        int          n;
        int          phase;
        int          phase_items [NUM_PHASES];
        logic [31:0] lim;
        logic [31:0] b8;
        logic [31:0] b16;
        logic [31:0] b32;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_request_bytes = 32'd0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = 32'd0;
        cfg_shadow      = '{MAX_REQ_RESET, BASE_RESET, BASE_RESET, BASE_RESET};
        for (k = 0; k < NUM_CLASSES; k++) slots_taken[k] = 0;

        // first rows run on the reset settings: bases 0, limit 4 MiB
        dir_rows[0]  = '{32'd8,          1'b1, '{ST_GRANT, CLS_8, 10'd0, 32'd0}};
        dir_rows[1]  = '{32'd0,          1'b1, '{ST_GRANT, CLS_8, 10'd1, 32'd8}};
        dir_rows[2]  = '{32'd9,          1'b1, '{ST_GRANT, CLS_16, 10'd0, 32'd0}};
        dir_rows[3]  = '{32'd16,         1'b1, '{ST_GRANT, CLS_16, 10'd1, 32'd16}};
        dir_rows[4]  = '{32'd17,         1'b1, '{ST_GRANT, CLS_32, 10'd0, 32'd0}};
        dir_rows[5]  = '{32'd32,         1'b1, '{ST_GRANT, CLS_32, 10'd1, 32'd32}};
        dir_rows[6]  = '{32'd33,         1'b1, '{ST_FALLBACK, CLS_8, 10'd0, 32'd0}};
        dir_rows[7]  = '{32'd4194304,    1'b1, '{ST_FALLBACK, CLS_8, 10'd0, 32'd0}};
        dir_rows[8]  = '{32'd4194305,    1'b1, '{ST_REJECT, CLS_8, 10'd0, 32'd0}};
        dir_rows[9]  = '{32'hFFFF_FFFF,  1'b1, '{ST_REJECT, CLS_8, 10'd0, 32'd0}};
        dir_rows[10] = '{32'd1,          1'b0, UNTYPED};
        dir_rows[11] = '{32'd7,          1'b0, UNTYPED};
        dir_rows[12] = '{32'd15,         1'b0, UNTYPED};
        dir_rows[13] = '{32'd31,         1'b0, UNTYPED};
        dir_rows[14] = '{32'd64,         1'b0, UNTYPED};
        dir_rows[15] = '{32'h8000_0000,  1'b0, UNTYPED};
        dir_rows[16] = '{32'h5555_5555,  1'b0, UNTYPED};
        dir_rows[17] = '{32'h003F_FFFF,  1'b0, UNTYPED};
        dir_rows[18] = '{32'd2,          1'b0, UNTYPED};
        dir_rows[19] = '{32'd24,         1'b0, UNTYPED};

        // the last phase sends only small requests so the 8-byte class runs out
        // and small requests spill into the 16-byte class
        phase_items = '{250, 50, 230, 100, 250, 600};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            i_in_valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge i_clk);
            case (phase)
                0: begin
                    lim = 32'hFFFF_FFFF;
                    b8 = $urandom(); b16 = $urandom(); b32 = $urandom();
                end
                1: begin
                    lim = 32'd0;
                    b8 = 32'hFFFF_FFFF; b16 = 32'hFFFF_FFFF; b32 = 32'hFFFF_FFFF;
                end
                2: begin
                    lim = 32'd32;
                    b8 = 32'hFFFF_FFF8; b16 = 32'hFFFF_FF00; b32 = 32'hFFFF_F000;
                end
                3: begin
                    lim = 32'd16;
                    b8 = 32'd0; b16 = 32'd0; b32 = 32'd0;
                end
                4: begin
                    lim = $urandom_range(32'hFFFF_FFFF, 33);
                    b8 = $urandom(); b16 = $urandom(); b32 = $urandom();
                end
                default: begin
                    lim = 32'hFFFF_FFFF;
                    b8 = $urandom(); b16 = $urandom(); b32 = $urandom();
                end
            endcase
            apb_write(REG_MAX_REQ, lim);
            apb_write(REG_BASE8, b8);
            apb_write(REG_BASE16, b16);
            apb_write(REG_BASE32, b32);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge i_clk);

            for (n = 0; n < phase_items[phase]; n++) begin
                // now and then run a stretch with no idling on either side
                if (n % 64 == 0) begin
                    quiet_in  <= ($urandom_range(0, 4) == 0);
                    quiet_out <= ($urandom_range(0, 4) == 0);
                end
                send_request((phase == NUM_PHASES - 1) ? $urandom_range(0, 8) : pick_request(),
                             1'b0, UNTYPED);
            end
        end

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/scsba_pkg.sv
rtl/scsba_cfg.sv
rtl/scsba_ctrl.sv
rtl/scsba_dp.sv
rtl/size_class_slab_bitmap_allocator.sv
bench/testbench.sv
